[src/pooled_linked_list_engine_macros.svh]
// Assertion macros for the pooled linked-list engine.
// Included by modules that carry concurrent checks; uses clock and reset.
`ifndef POOLED_LINKED_LIST_ENGINE_MACROS_SVH
`define POOLED_LINKED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define PLLE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PLLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/plle_pkg.sv]
// Shared types and constants for the pooled linked-list engine.
// No dependencies.
package plle_pkg;

   localparam int SLOTS     = 64;
   localparam int DATA_BITS = 32;
   localparam int SLOT_W    = 7;
   localparam int IDX_W     = $clog2(SLOTS);
   localparam int POS_W     = 6;
   localparam int CMD_W     = 4;
   localparam int ADDR_W    = 3;
   localparam logic [ADDR_W-1:0] ADDR_ROTATE = 3'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH       = 4'd0,
      CMD_POPFRONT   = 4'd1,
      CMD_GETAT      = 4'd2,
      CMD_SETAT      = 4'd3,
      CMD_REMOVEAT   = 4'd4,
      CMD_GETSLOT    = 4'd5,
      CMD_SETSLOT    = 4'd6,
      CMD_REMOVESLOT = 4'd7,
      CMD_NEXT       = 4'd8,
      CMD_CLEAR      = 4'd9,
      CMD_FRONT      = 4'd10,
      CMD_BACK       = 4'd11
   } cmd_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SETUP_HEAD,
      OP_SETUP_TAIL,
      OP_SETUP_SID,
      OP_SETUP_FREE,
      OP_STEP,
      OP_SET_ELEM,
      OP_UL1,
      OP_UL2,
      OP_UL3,
      OP_PUSH2,
      OP_PUSH3,
      OP_CLR1,
      OP_CLR2
   } op_type;

   typedef struct packed {
      op_type op;
      logic   set_ok;
      logic   grab_data;
      logic   slot_cur;
      logic   slot_link;
      logic   out_load;
   } ctl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    count_zero;
      logic    full;
      logic    free_zero;
      logic    pos_ok;
      logic    sid_ok;
      logic    walk_hit;
      logic    walk_end;
      logic    rotate;
   } stat_type;

   // link value of a never-written entry: next slot, last slot links to none
   function automatic logic [SLOT_W-1:0] link_default(input logic [IDX_W-1:0] idx);
      logic [SLOT_W-1:0] res;
      if (idx == IDX_W'(SLOTS - 1)) res = '0;
      else res = SLOT_W'(idx) + SLOT_W'(2);
      return res;
   endfunction

   function automatic logic [IDX_W-1:0] slot_idx(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] d;
      d = slot - SLOT_W'(1);
      return d[IDX_W-1:0];
   endfunction

endpackage

[src/plle_if.sv]
// Valid/ready channel interfaces for the pooled linked-list engine.
// Depends on plle_pkg.
interface plle_req_if;
   logic                           valid;
   logic                           ready;
   logic [plle_pkg::CMD_W-1:0]     cmd;
   logic [plle_pkg::POS_W-1:0]     elem_index;
   logic [plle_pkg::SLOT_W-1:0]    slot_id;
   logic [plle_pkg::DATA_BITS-1:0] data_in;
   modport source (output valid, cmd, elem_index, slot_id, data_in, input ready);
   modport sink (input valid, cmd, elem_index, slot_id, data_in, output ready);
endinterface

interface plle_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           ok;
   logic [plle_pkg::DATA_BITS-1:0] data_out;
   logic [plle_pkg::SLOT_W-1:0]    slot_out;
   logic [plle_pkg::SLOT_W-1:0]    list_size;
   logic [plle_pkg::SLOT_W-1:0]    free_count;
   logic [plle_pkg::SLOT_W-1:0]    head_slot;
   logic [plle_pkg::SLOT_W-1:0]    tail_slot;
   modport source (output valid, ok, data_out, slot_out, list_size, free_count,
                   head_slot, tail_slot, input ready);
   modport sink (input valid, ok, data_out, slot_out, list_size, free_count,
                 head_slot, tail_slot, output ready);
endinterface

[src/plle_datapath.sv]
// Datapath: link and element stores, list and free-list registers, walk logic.
// Depends on plle_pkg and pooled_linked_list_engine_macros.svh.
`include "pooled_linked_list_engine_macros.svh"

module plle_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  plle_pkg::ctl_cmd_type          ctl,
   output plle_pkg::stat_type             stat,
   input  logic [plle_pkg::CMD_W-1:0]     req_cmd,
   input  logic [plle_pkg::POS_W-1:0]     req_elem_index,
   input  logic [plle_pkg::SLOT_W-1:0]    req_slot_id,
   input  logic [plle_pkg::DATA_BITS-1:0] req_data_in,
   input  logic                           rotate,
   output logic                           rsp_ok,
   output logic [plle_pkg::DATA_BITS-1:0] rsp_data_out,
   output logic [plle_pkg::SLOT_W-1:0]    rsp_slot_out,
   output logic [plle_pkg::SLOT_W-1:0]    rsp_list_size,
   output logic [plle_pkg::SLOT_W-1:0]    rsp_free_count,
   output logic [plle_pkg::SLOT_W-1:0]    rsp_head_slot,
   output logic [plle_pkg::SLOT_W-1:0]    rsp_tail_slot
);

   logic [plle_pkg::SLOT_W-1:0]    link_mem [plle_pkg::SLOTS];
   logic [plle_pkg::DATA_BITS-1:0] elem_mem [plle_pkg::SLOTS];
   logic [plle_pkg::SLOTS-1:0]     link_vld_ff;

   logic [plle_pkg::SLOT_W-1:0]    link_rdata_ff;
   logic                           link_rvld_ff;
   logic [plle_pkg::IDX_W-1:0]     link_ridx_ff;
   logic [plle_pkg::DATA_BITS-1:0] elem_rdata_ff;
   logic [plle_pkg::SLOT_W-1:0]    link_q;

   plle_pkg::cmd_type              cmd_ff;
   logic [plle_pkg::POS_W-1:0]     pos_ff;
   logic [plle_pkg::SLOT_W-1:0]    sid_ff;
   logic [plle_pkg::DATA_BITS-1:0] din_ff;

   logic [plle_pkg::SLOT_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [plle_pkg::SLOT_W-1:0] fhead_ff, fhead_in, ftail_ff, ftail_in;
   logic [plle_pkg::SLOT_W-1:0] count_ff, count_in, fcount_ff, fcount_in;
   logic [plle_pkg::SLOT_W-1:0] cur_ff, cur_in, prev_ff, prev_in, step_ff, step_in;

   logic                           res_ok_ff;
   logic [plle_pkg::DATA_BITS-1:0] res_data_ff;
   logic [plle_pkg::SLOT_W-1:0]    res_slot_ff;

   logic                        rd_en;
   logic [plle_pkg::SLOT_W-1:0] rd_slot;
   logic                        lwr_en;
   logic [plle_pkg::SLOT_W-1:0] lwr_slot, lwr_data;
   logic                        ewr_en;

   assign link_q = link_rvld_ff ? link_rdata_ff : plle_pkg::link_default(link_ridx_ff);

   always_comb begin
      rd_en = 1'b1;
      rd_slot = head_ff;
      case (ctl.op)
         plle_pkg::OP_SETUP_HEAD: rd_slot = head_ff;
         plle_pkg::OP_SETUP_TAIL: rd_slot = tail_ff;
         plle_pkg::OP_SETUP_SID:  rd_slot = sid_ff;
         plle_pkg::OP_SETUP_FREE: rd_slot = fhead_ff;
         plle_pkg::OP_STEP:       rd_slot = link_q;
         default:                 rd_en = 1'b0;
      endcase
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fhead_in = fhead_ff;
      ftail_in = ftail_ff;
      count_in = count_ff;
      fcount_in = fcount_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      step_in = step_ff;
      lwr_en = 1'b0;
      lwr_slot = cur_ff;
      lwr_data = '0;
      ewr_en = 1'b0;
      case (ctl.op)
         plle_pkg::OP_SETUP_HEAD, plle_pkg::OP_SETUP_TAIL, plle_pkg::OP_SETUP_SID,
         plle_pkg::OP_SETUP_FREE: begin
            cur_in = rd_slot;
            prev_in = '0;
            step_in = '0;
         end
         plle_pkg::OP_STEP: begin
            prev_in = cur_ff;
            cur_in = link_q;
            step_in = step_ff + plle_pkg::SLOT_W'(1);
         end
         plle_pkg::OP_SET_ELEM: ewr_en = 1'b1;
         plle_pkg::OP_UL1: begin
            if (prev_ff == '0) begin
               head_in = link_q;
            end else begin
               lwr_en = 1'b1;
               lwr_slot = prev_ff;
               lwr_data = link_q;
            end
            if (tail_ff == cur_ff) tail_in = prev_ff;
         end
         plle_pkg::OP_UL2: lwr_en = 1'b1;
         plle_pkg::OP_UL3: begin
            if (fcount_ff == '0) begin
               fhead_in = cur_ff;
            end else begin
               lwr_en = 1'b1;
               lwr_slot = ftail_ff;
               lwr_data = cur_ff;
            end
            ftail_in = cur_ff;
            fcount_in = fcount_ff + plle_pkg::SLOT_W'(1);
            count_in = count_ff - plle_pkg::SLOT_W'(1);
            if (count_ff == plle_pkg::SLOT_W'(1)) begin
               head_in = '0;
               tail_in = '0;
            end
         end
         plle_pkg::OP_PUSH2: begin
            fhead_in = link_q;
            fcount_in = fcount_ff - plle_pkg::SLOT_W'(1);
            if (fcount_ff == plle_pkg::SLOT_W'(1)) begin
               fhead_in = '0;
               ftail_in = '0;
            end
            lwr_en = 1'b1;
            ewr_en = 1'b1;
         end
         plle_pkg::OP_PUSH3: begin
            if (count_ff == '0) begin
               head_in = cur_ff;
            end else begin
               lwr_en = 1'b1;
               lwr_slot = tail_ff;
               lwr_data = cur_ff;
            end
            tail_in = cur_ff;
            count_in = count_ff + plle_pkg::SLOT_W'(1);
         end
         plle_pkg::OP_CLR1: begin
            if (fcount_ff == '0) begin
               fhead_in = head_ff;
            end else begin
               lwr_en = 1'b1;
               lwr_slot = ftail_ff;
               lwr_data = head_ff;
            end
         end
         plle_pkg::OP_CLR2: begin
            lwr_en = 1'b1;
            lwr_slot = tail_ff;
            ftail_in = tail_ff;
            fcount_in = fcount_ff + count_ff;
            count_in = '0;
            head_in = '0;
            tail_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         link_rdata_ff <= link_mem[plle_pkg::slot_idx(rd_slot)];
         link_rvld_ff <= link_vld_ff[plle_pkg::slot_idx(rd_slot)];
         link_ridx_ff <= plle_pkg::slot_idx(rd_slot);
         elem_rdata_ff <= elem_mem[plle_pkg::slot_idx(rd_slot)];
      end
      if (lwr_en) link_mem[plle_pkg::slot_idx(lwr_slot)] <= lwr_data;
      if (ewr_en) elem_mem[plle_pkg::slot_idx(cur_ff)] <= din_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         fhead_ff <= plle_pkg::SLOT_W'(1);
         ftail_ff <= plle_pkg::SLOT_W'(plle_pkg::SLOTS);
         count_ff <= '0;
         fcount_ff <= plle_pkg::SLOT_W'(plle_pkg::SLOTS);
      end else begin
         if (lwr_en) link_vld_ff[plle_pkg::slot_idx(lwr_slot)] <= 1'b1;
         head_ff <= head_in;
         tail_ff <= tail_in;
         fhead_ff <= fhead_in;
         ftail_ff <= ftail_in;
         count_ff <= count_in;
         fcount_ff <= fcount_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      step_ff <= step_in;
      if (ctl.op == plle_pkg::OP_LOAD) begin
         cmd_ff <= plle_pkg::cmd_type'(req_cmd);
         pos_ff <= req_elem_index;
         sid_ff <= req_slot_id;
         din_ff <= req_data_in;
         res_ok_ff <= 1'b0;
         res_data_ff <= '0;
         res_slot_ff <= '0;
      end else begin
         if (ctl.set_ok) res_ok_ff <= 1'b1;
         if (ctl.grab_data) res_data_ff <= elem_rdata_ff;
         if (ctl.slot_cur) res_slot_ff <= cur_ff;
         if (ctl.slot_link) res_slot_ff <= link_q;
      end
      if (ctl.out_load) begin
         rsp_ok <= res_ok_ff;
         rsp_data_out <= res_data_ff;
         rsp_slot_out <= res_slot_ff;
         rsp_list_size <= count_ff;
         rsp_free_count <= fcount_ff;
         rsp_head_slot <= head_ff;
         rsp_tail_slot <= tail_ff;
      end
   end

   always_comb begin
      stat.cmd = cmd_ff;
      stat.count_zero = (count_ff == '0);
      stat.full = (count_ff == plle_pkg::SLOT_W'(plle_pkg::SLOTS));
      stat.free_zero = (fcount_ff == '0);
      stat.pos_ok = (plle_pkg::SLOT_W'(pos_ff) < count_ff);
      stat.sid_ok = (sid_ff != '0) && (sid_ff <= plle_pkg::SLOT_W'(plle_pkg::SLOTS));
      stat.rotate = rotate;
      stat.walk_end = (cmd_ff == plle_pkg::CMD_REMOVESLOT) && (step_ff == count_ff);
      case (cmd_ff)
         plle_pkg::CMD_GETAT, plle_pkg::CMD_SETAT, plle_pkg::CMD_REMOVEAT:
            stat.walk_hit = (step_ff == plle_pkg::SLOT_W'(pos_ff));
         plle_pkg::CMD_REMOVESLOT: stat.walk_hit = (cur_ff == sid_ff);
         default: stat.walk_hit = 1'b1;
      endcase
   end

   // free count drops at OP_PUSH2, ahead of the list count rise at OP_PUSH3
   `PLLE_ASSERT_NOW(a_pool_total, ctl.op != plle_pkg::OP_PUSH3,
      (count_ff + fcount_ff) == plle_pkg::SLOT_W'(plle_pkg::SLOTS), "slots lost from pool")
   `PLLE_ASSERT_NOW(a_empty_ends, count_ff == '0, head_ff == '0 && tail_ff == '0,
      "empty list has ends")
   `PLLE_ASSERT_NEXT(a_unlink_free, ctl.op == plle_pkg::OP_UL3,
      fcount_ff == $past(fcount_ff) + plle_pkg::SLOT_W'(1), "free count not bumped")

endmodule

[src/plle_ctrl.sv]
// Controller: sequences each command through the datapath and owns rsp valid.
// Depends on plle_pkg.
module plle_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  plle_pkg::stat_type    stat,
   output plle_pkg::ctl_cmd_type ctl
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISP, ST_WALK, ST_UL1, ST_UL2, ST_UL3,
      ST_PUSH1, ST_PUSH2, ST_PUSH3, ST_CLR1, ST_CLR2, ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl = '0;
      ctl.op = plle_pkg::OP_NONE;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.op = plle_pkg::OP_LOAD;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            state_in = ST_FIN;
            case (stat.cmd)
               plle_pkg::CMD_PUSH: begin
                  if (stat.full && stat.rotate) begin
                     ctl.op = plle_pkg::OP_SETUP_HEAD;
                     state_in = ST_UL1;
                  end else if (!stat.free_zero) begin
                     state_in = ST_PUSH1;
                  end
               end
               plle_pkg::CMD_POPFRONT, plle_pkg::CMD_FRONT: begin
                  if (!stat.count_zero) begin
                     ctl.op = plle_pkg::OP_SETUP_HEAD;
                     state_in = ST_WALK;
                  end
               end
               plle_pkg::CMD_BACK: begin
                  if (!stat.count_zero) begin
                     ctl.op = plle_pkg::OP_SETUP_TAIL;
                     state_in = ST_WALK;
                  end
               end
               plle_pkg::CMD_GETAT, plle_pkg::CMD_SETAT, plle_pkg::CMD_REMOVEAT: begin
                  if (stat.pos_ok) begin
                     ctl.op = plle_pkg::OP_SETUP_HEAD;
                     state_in = ST_WALK;
                  end
               end
               plle_pkg::CMD_GETSLOT, plle_pkg::CMD_SETSLOT, plle_pkg::CMD_NEXT: begin
                  if (stat.sid_ok) begin
                     ctl.op = plle_pkg::OP_SETUP_SID;
                     state_in = ST_WALK;
                  end
               end
               plle_pkg::CMD_REMOVESLOT: begin
                  if (stat.sid_ok) begin
                     ctl.op = plle_pkg::OP_SETUP_HEAD;
                     state_in = ST_WALK;
                  end
               end
               plle_pkg::CMD_CLEAR: begin
                  ctl.set_ok = 1'b1;
                  if (!stat.count_zero) state_in = ST_CLR1;
               end
               default: state_in = ST_FIN;
            endcase
         end
         ST_WALK: begin
            if (stat.walk_end) begin
               state_in = ST_FIN;
            end else if (!stat.walk_hit) begin
               ctl.op = plle_pkg::OP_STEP;
            end else begin
               ctl.set_ok = 1'b1;
               state_in = ST_FIN;
               case (stat.cmd)
                  plle_pkg::CMD_POPFRONT: begin
                     ctl.op = plle_pkg::OP_UL1;
                     ctl.grab_data = 1'b1;
                     ctl.slot_cur = 1'b1;
                     state_in = ST_UL2;
                  end
                  plle_pkg::CMD_REMOVEAT, plle_pkg::CMD_REMOVESLOT: begin
                     ctl.op = plle_pkg::OP_UL1;
                     ctl.slot_cur = 1'b1;
                     state_in = ST_UL2;
                  end
                  plle_pkg::CMD_SETAT, plle_pkg::CMD_SETSLOT: begin
                     ctl.op = plle_pkg::OP_SET_ELEM;
                     ctl.slot_cur = 1'b1;
                  end
                  plle_pkg::CMD_NEXT: ctl.slot_link = 1'b1;
                  default: begin
                     ctl.grab_data = 1'b1;
                     ctl.slot_cur = 1'b1;
                  end
               endcase
            end
         end
         ST_UL1: begin
            ctl.op = plle_pkg::OP_UL1;
            state_in = ST_UL2;
         end
         ST_UL2: begin
            ctl.op = plle_pkg::OP_UL2;
            state_in = ST_UL3;
         end
         ST_UL3: begin
            ctl.op = plle_pkg::OP_UL3;
            state_in = (stat.cmd == plle_pkg::CMD_PUSH) ? ST_PUSH1 : ST_FIN;
         end
         ST_PUSH1: begin
            ctl.op = plle_pkg::OP_SETUP_FREE;
            state_in = ST_PUSH2;
         end
         ST_PUSH2: begin
            ctl.op = plle_pkg::OP_PUSH2;
            state_in = ST_PUSH3;
         end
         ST_PUSH3: begin
            ctl.op = plle_pkg::OP_PUSH3;
            ctl.set_ok = 1'b1;
            ctl.slot_cur = 1'b1;
            state_in = ST_FIN;
         end
         ST_CLR1: begin
            ctl.op = plle_pkg::OP_CLR1;
            state_in = ST_CLR2;
         end
         ST_CLR2: begin
            ctl.op = plle_pkg::OP_CLR2;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!(rsp_valid_ff && !rsp_ready)) begin
               ctl.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= ctl.out_load || (rsp_valid_ff && !rsp_ready);
      end
   end

endmodule

[src/pooled_linked_list_engine.sv]
// Top level of the pooled linked-list engine: channels, CSR port, ctrl and datapath.
// Depends on plle_pkg, plle_if, plle_ctrl and plle_datapath.
//
// Usage: commands arrive on req_ch (valid/ready); each transfer produces one
// response on rsp_ch. One command is worked at a time; req_ch.ready is high
// while the engine is idle, even if the previous response still waits.
// Get, set and remove by position walk k links from the head (k up to 63);
// remove by slot walks until it hits the slot or has walked the whole list.
// The walk reads one link-store entry per cycle. A new command is taken only
// after the response of the last one is loaded into the output register.
// The CSR port holds rotate_when_full at byte address 0; write only while idle.
// Reset (synchronous) empties the list and returns all 64 slots to the free
// list at once; element data stays undefined until written.
// A stalled response holds in the output register; the engine finishes the
// next command and then waits until that response transfer completes.
module pooled_linked_list_engine (
   input  logic                          clock,
   input  logic                          reset,
   plle_req_if.sink                      req_ch,
   plle_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [plle_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   plle_pkg::ctl_cmd_type ctl;
   plle_pkg::stat_type    stat;
   logic                  rotate_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == plle_pkg::ADDR_ROTATE) ? {31'b0, rotate_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotate_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == plle_pkg::ADDR_ROTATE) begin
         rotate_ff <= csr_pwdata[0];
      end
   end

   plle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   plle_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .req_cmd        (req_ch.cmd),
      .req_elem_index (req_ch.elem_index),
      .req_slot_id    (req_ch.slot_id),
      .req_data_in    (req_ch.data_in),
      .rotate         (rotate_ff),
      .rsp_ok         (rsp_ch.ok),
      .rsp_data_out   (rsp_ch.data_out),
      .rsp_slot_out   (rsp_ch.slot_out),
      .rsp_list_size  (rsp_ch.list_size),
      .rsp_free_count (rsp_ch.free_count),
      .rsp_head_slot  (rsp_ch.head_slot),
      .rsp_tail_slot  (rsp_ch.tail_slot)
   );

endmodule
